/* rtl/cabs_pkg.sv */
// types, codes and the mode/kind table of the addressing-mode bus sequencer
// no dependencies
package cabs_pkg;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_OP_LO  = 4'd1,
		PH_OP_HI  = 4'd2,
		PH_DUMMY  = 4'd3,
		PH_PTR_LO = 4'd4,
		PH_PTR_HI = 4'd5,
		PH_DATA   = 4'd6,
		PH_WRITE  = 4'd7,
		PH_RMW_DW = 4'd8,
		PH_MODIFY = 4'd9,
		PH_RMW_W  = 4'd10
	} phase_t;

	localparam logic [1:0] MODE_START    = 2'd0;
	localparam logic [1:0] MODE_ACK      = 2'd1;
	localparam logic [1:0] MODE_MODIFIED = 2'd2;

	localparam logic [3:0] AM_ABS      = 4'd0;
	localparam logic [3:0] AM_ABSX     = 4'd1;
	localparam logic [3:0] AM_ABSY     = 4'd2;
	localparam logic [3:0] AM_ACC      = 4'd3;
	localparam logic [3:0] AM_IMM      = 4'd4;
	localparam logic [3:0] AM_IMP      = 4'd5;
	localparam logic [3:0] AM_IND      = 4'd6;
	localparam logic [3:0] AM_ZP       = 4'd7;
	localparam logic [3:0] AM_ZPX      = 4'd8;
	localparam logic [3:0] AM_ZPY      = 4'd9;
	localparam logic [3:0] AM_ZPX_IND  = 4'd10;
	localparam logic [3:0] AM_ZP_IND_Y = 4'd11;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_RMW   = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	localparam logic [1:0] ACT_READ   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_MODIFY = 2'd2;
	localparam logic [1:0] ACT_DONE   = 2'd3;

	localparam logic [15:0] PAGE_MASK = 16'hFF00;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  addressing_mode;
		logic [1:0]  access_kind;
		logic [15:0] start_pc;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  accumulator;
		logic [7:0]  data_value;
		logic [7:0]  bus_data;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  mode_held;
		logic [1:0]  kind_held;
		logic [15:0] pc_reg;
		logic [7:0]  x_held;
		logic [7:0]  y_held;
		logic [7:0]  a_held;
		logic [7:0]  store_byte;
		logic [7:0]  low_byte;
		logic [7:0]  high_byte;
		logic [15:0] base_address;
		logic [15:0] operand_address;
		logic [7:0]  operand_byte;
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
		logic [15:0] effective_address;
		logic [7:0]  fetched_data;
		logic [15:0] next_pc;
		logic        bad_request;
	} result_t;

	// bit k set: access kind k allowed for that addressing mode
	function automatic logic [2:0] kinds_ok(input logic [3:0] am);
		logic [2:0] k;
		case (am)
			AM_ABS, AM_ABSX, AM_ZP, AM_ZPX:          k = 3'b111;
			AM_ABSY, AM_ZPY, AM_ZPX_IND, AM_ZP_IND_Y: k = 3'b011;
			AM_ACC, AM_IMM, AM_IMP, AM_IND:          k = 3'b001;
			default:                                 k = 3'b000;
		endcase
		return k;
	endfunction

endpackage

/* rtl/cabs_step.sv */
// next-state and result logic for one transaction of the bus sequencer
// depends on cabs_pkg
module cabs_step (
	input  cabs_pkg::item_t   item,
	input  cabs_pkg::state_t  cur,
	output cabs_pkg::state_t  nxt,
	output cabs_pkg::result_t res
);

	typedef struct packed {
		cabs_pkg::phase_t phase;
		logic [1:0]       action;
		logic [15:0]      addr;
		logic [7:0]       wdata;
	} req_t;

	function automatic req_t rd(input cabs_pkg::phase_t ph, input logic [15:0] a);
		return '{ph, cabs_pkg::ACT_READ, a, 8'h00};
	endfunction

	// operand address known: go access it
	function automatic req_t access(input logic [1:0] kind, input logic [15:0] oa,
			input logic [7:0] sb);
		req_t r;
		if (kind == cabs_pkg::KIND_WRITE)
			r = '{cabs_pkg::PH_WRITE, cabs_pkg::ACT_WRITE, oa, sb};
		else
			r = rd(cabs_pkg::PH_DATA, oa);
		return r;
	endfunction

	// plain read staying in page skips the dummy read at the base
	function automatic req_t indexed(input logic [1:0] kind, input logic [15:0] base,
			input logic [15:0] oa, input logic [7:0] sb);
		req_t r;
		if (kind == cabs_pkg::KIND_READ &&
				(base & cabs_pkg::PAGE_MASK) == (oa & cabs_pkg::PAGE_MASK))
			r = access(kind, oa, sb);
		else
			r = rd(cabs_pkg::PH_DUMMY, base);
		return r;
	endfunction

	req_t        r;
	logic        bad;
	logic [7:0]  b;
	logic [15:0] pc_inc;
	logic [15:0] hi_base;
	logic [15:0] ptr;
	logic [7:0]  zp_idx;
	logic [2:0]  ok;

	always_comb begin
		nxt     = cur;
		r       = '{cabs_pkg::PH_IDLE, cabs_pkg::ACT_DONE, 16'h0000, 8'h00};
		bad     = 1'b0;
		b       = item.bus_data;
		pc_inc  = cur.pc_reg + 16'd1;
		hi_base = {b, cur.low_byte};
		ptr     = {b, cur.low_byte};
		zp_idx  = cur.base_address[7:0] +
			((cur.mode_held == cabs_pkg::AM_ZPX) ? cur.x_held : cur.y_held);
		ok      = cabs_pkg::kinds_ok(item.addressing_mode);
		case (item.mode)
			cabs_pkg::MODE_START: begin
				if (cur.phase != cabs_pkg::PH_IDLE || item.access_kind == cabs_pkg::KIND_BAD ||
						!ok[item.access_kind[1:0]]) begin
					bad = 1'b1;
				end else begin
					nxt.mode_held       = item.addressing_mode;
					nxt.kind_held       = item.access_kind;
					nxt.pc_reg          = item.start_pc;
					nxt.x_held          = item.index_x;
					nxt.y_held          = item.index_y;
					nxt.a_held          = item.accumulator;
					nxt.store_byte      = item.data_value;
					nxt.low_byte        = 8'h00;
					nxt.high_byte       = 8'h00;
					nxt.base_address    = 16'h0000;
					nxt.operand_address = 16'h0000;
					nxt.operand_byte    = 8'h00;
					r = rd(cabs_pkg::PH_OP_LO, item.start_pc);
				end
			end
			cabs_pkg::MODE_ACK: begin
				case (cur.phase)
					cabs_pkg::PH_OP_LO: begin
						if (cur.mode_held == cabs_pkg::AM_ACC) begin
							nxt.operand_byte = cur.a_held;
						end else if (cur.mode_held == cabs_pkg::AM_IMP) begin
							nxt.operand_byte = cur.operand_byte;
						end else if (cur.mode_held == cabs_pkg::AM_IMM) begin
							nxt.operand_address = cur.pc_reg;
							nxt.operand_byte    = b;
							nxt.pc_reg          = pc_inc;
						end else begin
							nxt.pc_reg = pc_inc;
							if (cur.mode_held == cabs_pkg::AM_ZP) begin
								nxt.operand_address = {8'h00, b};
								r = access(cur.kind_held, {8'h00, b}, cur.store_byte);
							end else begin
								nxt.base_address = {8'h00, b};
								if (cur.mode_held == cabs_pkg::AM_ZPX ||
										cur.mode_held == cabs_pkg::AM_ZPY ||
										cur.mode_held == cabs_pkg::AM_ZPX_IND)
									r = rd(cabs_pkg::PH_DUMMY, {8'h00, b});
								else if (cur.mode_held == cabs_pkg::AM_ZP_IND_Y)
									r = rd(cabs_pkg::PH_PTR_LO, {8'h00, b});
								else begin
									nxt.low_byte = b;
									r = rd(cabs_pkg::PH_OP_HI, pc_inc);
								end
							end
						end
					end
					cabs_pkg::PH_OP_HI: begin
						nxt.high_byte    = b;
						nxt.pc_reg       = pc_inc;
						nxt.base_address = hi_base;
						if (cur.mode_held == cabs_pkg::AM_IND) begin
							r = rd(cabs_pkg::PH_PTR_LO, hi_base);
						end else if (cur.mode_held == cabs_pkg::AM_ABS) begin
							nxt.operand_address = hi_base;
							r = access(cur.kind_held, hi_base, cur.store_byte);
						end else begin
							nxt.operand_address = hi_base + {8'h00,
								(cur.mode_held == cabs_pkg::AM_ABSX) ? cur.x_held : cur.y_held};
							r = indexed(cur.kind_held, hi_base, nxt.operand_address,
								cur.store_byte);
						end
					end
					cabs_pkg::PH_DUMMY: begin
						if (cur.mode_held == cabs_pkg::AM_ZPX ||
								cur.mode_held == cabs_pkg::AM_ZPY) begin
							// zero-page indexing wraps inside page zero
							nxt.operand_address = {8'h00, zp_idx};
							r = access(cur.kind_held, {8'h00, zp_idx}, cur.store_byte);
						end else if (cur.mode_held == cabs_pkg::AM_ZPX_IND) begin
							nxt.base_address = {8'h00, cur.base_address[7:0] + cur.x_held};
							r = rd(cabs_pkg::PH_PTR_LO, nxt.base_address);
						end else begin
							r = access(cur.kind_held, cur.operand_address, cur.store_byte);
						end
					end
					cabs_pkg::PH_PTR_LO: begin
						// pointer high byte never carries into the next page
						nxt.low_byte = b;
						r = rd(cabs_pkg::PH_PTR_HI,
							{cur.base_address[15:8], cur.base_address[7:0] + 8'd1});
					end
					cabs_pkg::PH_PTR_HI: begin
						nxt.high_byte = b;
						if (cur.mode_held == cabs_pkg::AM_IND) begin
							nxt.operand_address = ptr;
						end else if (cur.mode_held == cabs_pkg::AM_ZPX_IND) begin
							nxt.operand_address = ptr;
							r = access(cur.kind_held, ptr, cur.store_byte);
						end else begin
							nxt.base_address    = ptr;
							nxt.operand_address = ptr + {8'h00, cur.y_held};
							r = indexed(cur.kind_held, ptr, nxt.operand_address,
								cur.store_byte);
						end
					end
					cabs_pkg::PH_DATA: begin
						nxt.operand_byte = b;
						if (cur.kind_held == cabs_pkg::KIND_RMW)
							r = '{cabs_pkg::PH_RMW_DW, cabs_pkg::ACT_WRITE,
								cur.operand_address, b};
					end
					cabs_pkg::PH_RMW_DW: begin
						r = '{cabs_pkg::PH_MODIFY, cabs_pkg::ACT_MODIFY, 16'h0000, 8'h00};
					end
					cabs_pkg::PH_WRITE, cabs_pkg::PH_RMW_W: begin
						bad = 1'b0;
					end
					default: begin
						// idle or waiting for the modified byte
						bad = 1'b1;
					end
				endcase
			end
			cabs_pkg::MODE_MODIFIED: begin
				if (cur.phase == cabs_pkg::PH_MODIFY) begin
					nxt.operand_byte = item.data_value;
					r = '{cabs_pkg::PH_RMW_W, cabs_pkg::ACT_WRITE, cur.operand_address,
						item.data_value};
				end else begin
					bad = 1'b1;
				end
			end
			default: begin
				bad = 1'b1;
			end
		endcase
		nxt.phase = r.phase;
		res.action            = r.action;
		res.bus_address       = r.addr;
		res.write_data        = r.wdata;
		res.effective_address = nxt.operand_address;
		res.fetched_data      = nxt.operand_byte;
		res.next_pc           = nxt.pc_reg;
		res.bad_request       = bad;
	end

endmodule

/* rtl/cpu_addressing_mode_bus_sequencer.sv */
// 6502-style addressing-mode bus sequencer: input register, state step, result register
// depends on cabs_pkg and cabs_step
// an accepted transaction is registered in s1, stepped by cabs_step, and its result is registered in s2
// throughput: one transaction per cycle unless out_stall holds a result; the state loop is one pass through cabs_step
// reset: arst_n clears both valid bits and all sequencer state (phase idle)
// in_stall rises only while the result register holds an untaken result and s1 is full
module cpu_addressing_mode_bus_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  addressing_mode,
	input  logic [1:0]  access_kind,
	input  logic [15:0] start_pc,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [7:0]  accumulator,
	input  logic [7:0]  data_value,
	input  logic [7:0]  bus_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [15:0] bus_address,
	output logic [7:0]  write_data,
	output logic [15:0] effective_address,
	output logic [7:0]  fetched_data,
	output logic [15:0] next_pc,
	output logic        bad_request
);

	cabs_pkg::item_t   item_s1;
	logic              valid_s1;
	cabs_pkg::state_t  state_q;
	cabs_pkg::state_t  state_nxt;
	cabs_pkg::result_t res_nxt;
	cabs_pkg::result_t res_s2;
	logic              valid_s2;
	logic              advance;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	cabs_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1)
					state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= '{mode, addressing_mode, access_kind, start_pc, index_x, index_y,
				accumulator, data_value, bus_data};
		if (advance && valid_s1)
			res_s2 <= res_nxt;
	end

	assign out_valid         = valid_s2;
	assign action            = res_s2.action;
	assign bus_address       = res_s2.bus_address;
	assign write_data        = res_s2.write_data;
	assign effective_address = res_s2.effective_address;
	assign fetched_data      = res_s2.fetched_data;
	assign next_pc           = res_s2.next_pc;
	assign bad_request       = res_s2.bad_request;

	// a refused transaction always reports done
	a_bad_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> action == cabs_pkg::ACT_DONE)
		else $error("bad request without done");

	// write data is only driven on bus writes
	a_wdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != cabs_pkg::ACT_WRITE |-> write_data == 8'h00)
		else $error("write data on non-write result");

	// waiting for the modified byte only after a modify request went out
	a_modify_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == cabs_pkg::PH_MODIFY |-> res_s2.action == cabs_pkg::ACT_MODIFY)
		else $error("modify phase without modify request");

	// s1 holds its transaction unchanged while a waiting result stalls it
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost while stalled");

endmodule
